[rtl/rrhw_pkg.sv]
package rrhw_pkg;

  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned CRC_BYTES  = 4;
  localparam int unsigned MIN_FRAME  = 60;

  localparam logic [7:0] STAT_MASK = 8'h0f;
  localparam logic [7:0] STAT_GOOD = 8'h01;

  localparam logic [7:0]  RESET_START_PAGE = 8'd70;
  localparam logic [7:0]  RESET_STOP_PAGE  = 8'd128;
  localparam logic [15:0] RESET_MAX_LEN    = 16'd1514;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_STOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd2;

  // queue depth, a power of two
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OC_EMPTY     = 2'd0,
    OC_DELIVERED = 2'd1,
    OC_DROPPED   = 2'd2,
    OC_RESET     = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [7:0]  start_page;
    logic [7:0]  stop_page;
    logic [15:0] max_len;
  } cfg_t;

  // classified header, handed from front to back
  typedef struct packed {
    outcome_e    outcome;
    logic [15:0] frame_len;
    logic [7:0]  cur_page;
    logic [7:0]  boundary;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[rtl/rrhw_front.sv]
module rrhw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrhw_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  logic                fifo_full_i,
  input  logic [7:0]          write_page_i,
  input  logic [7:0]          hdr_status_i,
  input  logic [7:0]          hdr_next_page_i,
  input  logic [7:0]          hdr_len_low_i,
  output logic                in_ready_o,
  output logic                push_o,
  output rrhw_pkg::entry_t    entry_o
);
  import rrhw_pkg::*;

  logic [7:0]         npp_q, npp_d;
  logic signed [10:0] pages_fwd, pages_wrap, pages;
  logic signed [19:0] len_s;
  logic               is_empty, bad_ptr, bad_len, ring_reset, good_stat;
  logic [7:0]         bnd_raw, bnd;

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign is_empty = (npp_q == write_page_i);

  assign pages_fwd  = $signed({3'b000, hdr_next_page_i}) - $signed({3'b000, npp_q}) - 11'sd1;
  assign pages_wrap = ($signed({3'b000, cfg_i.stop_page}) - $signed({3'b000, npp_q}))
                    + ($signed({3'b000, hdr_next_page_i}) - $signed({3'b000, cfg_i.start_page}))
                    - 11'sd1;

  always_comb begin
    pages = (hdr_next_page_i > npp_q) ? pages_fwd : pages_wrap;
    // count byte past the page body means one page less
    if (hdr_len_low_i > 8'(PAGE_BYTES - HDR_BYTES)) begin
      pages = pages - 11'sd1;
    end
  end

  assign len_s = $signed({pages[10], pages, 8'h00}) + $signed({12'h000, hdr_len_low_i})
               - 20'sd4;

  assign bad_ptr = (hdr_next_page_i < cfg_i.start_page) ||
                   (hdr_next_page_i >= cfg_i.stop_page);
  // negative lengths fall below the minimum too
  assign bad_len = (len_s < $signed(20'(MIN_FRAME))) ||
                   (!len_s[19] && (len_s[18:0] > {3'b000, cfg_i.max_len}));
  assign ring_reset = bad_ptr || bad_len;
  assign good_stat  = ((hdr_status_i & STAT_MASK) == STAT_GOOD);

  assign bnd_raw = hdr_next_page_i - 8'd1;
  assign bnd     = (bnd_raw < cfg_i.start_page) ? (cfg_i.stop_page - 8'd1) : bnd_raw;

  always_comb begin
    entry_o.cur_page  = npp_q;
    entry_o.outcome   = OC_EMPTY;
    entry_o.frame_len = '0;
    entry_o.boundary  = '0;
    npp_d             = npp_q;
    if (is_empty) begin
      entry_o.outcome = OC_EMPTY;
    end else if (ring_reset) begin
      entry_o.outcome  = OC_RESET;
      entry_o.boundary = cfg_i.stop_page - 8'd1;
      npp_d            = cfg_i.start_page;
    end else begin
      entry_o.boundary = bnd;
      npp_d            = hdr_next_page_i;
      if (good_stat) begin
        entry_o.outcome   = OC_DELIVERED;
        entry_o.frame_len = len_s[15:0];
      end else begin
        entry_o.outcome = OC_DROPPED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npp_q <= RESET_START_PAGE;
    end else if (push_o) begin
      npp_q <= npp_d;
    end
  end

endmodule

[rtl/rrhw_fifo.sv]
module rrhw_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rrhw_pkg::entry_t       push_data_i,
  input  logic                   pop_i,
  output rrhw_pkg::entry_t       head_o,
  output rrhw_pkg::fifo_status_t status_o
);
  import rrhw_pkg::*;

  entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  assign status_o.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/rrhw_back.sv]
module rrhw_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrhw_pkg::cfg_t         cfg_i,
  input  rrhw_pkg::entry_t       head_i,
  input  rrhw_pkg::fifo_status_t status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             outcome_o,
  output logic [15:0]            frame_len_o,
  output logic [15:0]            first_addr_o,
  output logic [15:0]            first_count_o,
  output logic [15:0]            second_addr_o,
  output logic [15:0]            second_count_o,
  output logic [7:0]             boundary_page_o
);
  import rrhw_pkg::*;

  logic        out_valid_q;
  logic [1:0]  outcome_q;
  logic [15:0] frame_len_q, first_addr_q, first_count_q, second_addr_q, second_count_q;
  logic [7:0]  boundary_q;

  logic [15:0] data_addr, stop_addr, fc, sc;
  logic [16:0] end_addr;
  logic        delivered, wraps;

  assign pop_o = !status_i.empty && (!out_valid_q || out_ready_i);

  assign delivered = (head_i.outcome == OC_DELIVERED);
  assign data_addr = {head_i.cur_page, 8'(HDR_BYTES)};
  assign stop_addr = {cfg_i.stop_page, 8'h00};
  assign end_addr  = {1'b0, data_addr} + {1'b0, head_i.frame_len};
  assign wraps     = (end_addr >= {1'b0, stop_addr});

  always_comb begin
    fc = head_i.frame_len;
    sc = '0;
    if (wraps) begin
      // data may already start beyond the stop address
      fc = (data_addr < stop_addr) ? (stop_addr - data_addr) : 16'h0000;
      sc = head_i.frame_len - fc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      outcome_q   <= head_i.outcome;
      frame_len_q <= head_i.frame_len;
      boundary_q  <= head_i.boundary;
      if (delivered) begin
        first_addr_q   <= data_addr;
        first_count_q  <= fc;
        second_count_q <= sc;
        second_addr_q  <= (sc != '0) ? {cfg_i.start_page, 8'h00} : 16'h0000;
      end else begin
        first_addr_q   <= '0;
        first_count_q  <= '0;
        second_count_q <= '0;
        second_addr_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = outcome_q;
  assign frame_len_o     = frame_len_q;
  assign first_addr_o    = first_addr_q;
  assign first_count_o   = first_count_q;
  assign second_addr_o   = second_addr_q;
  assign second_count_o  = second_count_q;
  assign boundary_page_o = boundary_q;

endmodule

[rtl/rx_ring_header_walker_top.sv]
// channel  | handshake                  | payload
// cfg      | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
// in       | in_valid_i / in_ready_o    | write_page_i, hdr_status_i, hdr_next_page_i,
//          |                            | hdr_len_low_i
// out      | out_valid_o / out_ready_i  | outcome_o, frame_len_o, first_addr_o, first_count_o,
//          |                            | second_addr_o, second_count_o, boundary_page_o
//
// one item per cycle sustained while out_ready_i stays high; the front classifies a
// header and updates the next-packet pointer in the cycle it is accepted, the back
// works out the copy spans. from acceptance an item passes through a two-entry
// queue and the output register before out_valid_o.
// reset restores the ring registers and sets the pointer to the ring start page.
// in_ready_o drops only when the queue is full; in a steady stream a stall on out
// fills it.
module rx_ring_header_walker_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrhw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rrhw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     write_page_i,
  input  logic [7:0]                     hdr_status_i,
  input  logic [7:0]                     hdr_next_page_i,
  input  logic [7:0]                     hdr_len_low_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     outcome_o,
  output logic [15:0]                    frame_len_o,
  output logic [15:0]                    first_addr_o,
  output logic [15:0]                    first_count_o,
  output logic [15:0]                    second_addr_o,
  output logic [15:0]                    second_count_o,
  output logic [7:0]                     boundary_page_o
);
  import rrhw_pkg::*;

  cfg_t         cfg_q;
  entry_t       push_entry, head_entry;
  fifo_status_t fifo_status;
  logic         push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_page <= RESET_START_PAGE;
      cfg_q.stop_page  <= RESET_STOP_PAGE;
      cfg_q.max_len    <= RESET_MAX_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RING_START: cfg_q.start_page <= cfg_wdata_i[7:0];
        CFG_RING_STOP:  cfg_q.stop_page  <= cfg_wdata_i[7:0];
        CFG_MAX_LEN:    cfg_q.max_len    <= cfg_wdata_i[15:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  rrhw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .fifo_full_i     (fifo_status.full),
    .write_page_i    (write_page_i),
    .hdr_status_i    (hdr_status_i),
    .hdr_next_page_i (hdr_next_page_i),
    .hdr_len_low_i   (hdr_len_low_i),
    .in_ready_o      (in_ready_o),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  rrhw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head_entry),
    .status_o    (fifo_status)
  );

  rrhw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head_entry),
    .status_i        (fifo_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .outcome_o       (outcome_o),
    .frame_len_o     (frame_len_o),
    .first_addr_o    (first_addr_o),
    .first_count_o   (first_count_o),
    .second_addr_o   (second_addr_o),
    .second_count_o  (second_count_o),
    .boundary_page_o (boundary_page_o)
  );

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OC_EMPTY) |-> (frame_len_o == '0 && boundary_page_o == '0))
    else $error("empty ring item carries nonzero fields");

  a_spans_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OC_DELIVERED) |->
      ({1'b0, first_count_o} + {1'b0, second_count_o} == {1'b0, frame_len_o}))
    else $error("copy spans do not add up to the frame length");

  a_no_spans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o != OC_DELIVERED) |->
      (first_count_o == '0 && second_count_o == '0 && frame_len_o == '0))
    else $error("spans reported for an undelivered frame");

  a_queue_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o) |-> in_ready_o)
    else $error("input stalled while the output side is empty");
`endif

endmodule

[bench/ring_walk_checker.sv]
`timescale 1ns / 1ps

module ring_walk_checker import rrhw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            write_page_i,
  input  logic [7:0]            hdr_status_i,
  input  logic [7:0]            hdr_next_page_i,
  input  logic [7:0]            hdr_len_low_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            outcome_i,
  input  logic [15:0]           frame_len_i,
  input  logic [15:0]           first_addr_i,
  input  logic [15:0]           first_count_i,
  input  logic [15:0]           second_addr_i,
  input  logic [15:0]           second_count_i,
  input  logic [7:0]            boundary_page_i,
  output logic [7:0]            next_page_o,
  output int                    pending_o,
  output int                    errors_o,
  output int                    delivered_o,
  output int                    split_o,
  output int                    dropped_o,
  output int                    resets_o,
  output int                    empty_o
);

  typedef struct packed {
    outcome_e    outcome;
    logic [15:0] frame_len;
    logic [15:0] first_addr;
    logic [15:0] first_count;
    logic [15:0] second_addr;
    logic [15:0] second_count;
    logic [7:0]  boundary;
  } walk_result_t;

  logic [7:0]   ring_start;
  logic [7:0]   ring_stop;
  logic [15:0]  max_len;
  walk_result_t walk_q[$];
  walk_result_t want;
  logic [7:0]   ptr_after;

  // classify one header against the current ring settings and pointer
  function automatic walk_result_t walk_header(input logic [7:0] wr, status, nxt, len_low,
                                               input logic [7:0] cur,
                                               output logic [7:0] new_ptr);
    walk_result_t r;
    int           pages, flen, cur_i, nxt_i, start_i, stop_i;
    int unsigned  data_a, stop_a, fc, sc, sa;
    logic [7:0]   bnd;
    r       = '0;
    new_ptr = cur;
    cur_i   = cur;
    nxt_i   = nxt;
    start_i = ring_start;
    stop_i  = ring_stop;
    if (cur == wr) begin
      r.outcome = OC_EMPTY;
      return r;
    end
    if (nxt > cur) begin
      pages = nxt_i - cur_i - 1;
    end else begin
      pages = (stop_i - cur_i) + (nxt_i - start_i) - 1;
    end
    // count byte past the last usable byte of a page means one page less
    if (int'(len_low) > int'(PAGE_BYTES - HDR_BYTES)) pages--;
    flen = pages * int'(PAGE_BYTES) + int'(len_low) - int'(CRC_BYTES);
    if (nxt < ring_start || nxt >= ring_stop || flen < int'(MIN_FRAME)
        || flen > int'(max_len)) begin
      new_ptr    = ring_start;
      r.outcome  = OC_RESET;
      r.boundary = ring_stop - 8'd1;
      return r;
    end
    new_ptr = nxt;
    bnd     = nxt - 8'd1;
    if (bnd < ring_start) bnd = ring_stop - 8'd1;
    r.boundary = bnd;
    if ((status & STAT_MASK) != STAT_GOOD) begin
      r.outcome = OC_DROPPED;
      return r;
    end
    data_a = cur_i * PAGE_BYTES + HDR_BYTES;
    stop_a = stop_i * PAGE_BYTES;
    fc     = flen;
    sc     = 0;
    sa     = 0;
    if (data_a + flen >= stop_a) begin
      fc = (data_a < stop_a) ? stop_a - data_a : 0;
      sc = flen - fc;
      if (sc != 0) sa = start_i * PAGE_BYTES;
    end
    r.outcome      = OC_DELIVERED;
    r.frame_len    = 16'(flen);
    r.first_addr   = 16'(data_a);
    r.first_count  = 16'(fc);
    r.second_addr  = 16'(sa);
    r.second_count = 16'(sc);
    return r;
  endfunction

  function automatic int diff_field(input string name, input logic [15:0] exp_v,
                                    input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_start  = RESET_START_PAGE;
      ring_stop   = RESET_STOP_PAGE;
      max_len     = RESET_MAX_LEN;
      next_page_o = RESET_START_PAGE;
      walk_q.delete();
      pending_o   = 0;
      errors_o    = 0;
      delivered_o = 0;
      split_o     = 0;
      dropped_o   = 0;
      resets_o    = 0;
      empty_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RING_START: ring_start = cfg_wdata_i[7:0];
          CFG_RING_STOP:  ring_stop  = cfg_wdata_i[7:0];
          CFG_MAX_LEN:    max_len    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (walk_q.size() == 0) begin
          $error("result with no item outstanding: outcome %0d", outcome_i);
          errors_o++;
        end else begin
          want = walk_q.pop_front();
          errors_o += diff_field("outcome", want.outcome, outcome_i);
          errors_o += diff_field("frame_len", want.frame_len, frame_len_i);
          errors_o += diff_field("first_addr", want.first_addr, first_addr_i);
          errors_o += diff_field("first_count", want.first_count, first_count_i);
          errors_o += diff_field("second_addr", want.second_addr, second_addr_i);
          errors_o += diff_field("second_count", want.second_count, second_count_i);
          errors_o += diff_field("boundary_page", want.boundary, boundary_page_i);
          case (want.outcome)
            OC_EMPTY:     empty_o++;
            OC_DELIVERED: delivered_o++;
            OC_DROPPED:   dropped_o++;
            default:      resets_o++;
          endcase
          if (want.second_count != 0) split_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        walk_q.push_back(walk_header(write_page_i, hdr_status_i, hdr_next_page_i,
                                     hdr_len_low_i, next_page_o, ptr_after));
        next_page_o = ptr_after;
      end
      pending_o = walk_q.size();
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import rrhw_pkg::*;

  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 88;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            write_page_i;
  logic [7:0]            hdr_status_i;
  logic [7:0]            hdr_next_page_i;
  logic [7:0]            hdr_len_low_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            outcome_o;
  logic [15:0]           frame_len_o;
  logic [15:0]           first_addr_o;
  logic [15:0]           first_count_o;
  logic [15:0]           second_addr_o;
  logic [15:0]           second_count_o;
  logic [7:0]            boundary_page_o;

  logic [7:0]  ring_ptr;
  int          pending, errors;
  int          n_delivered, n_split, n_dropped, n_resets, n_empty;
  int          n_items, n_settings;
  logic [7:0]  cfg_start, cfg_stop;
  logic [15:0] cfg_max;
  logic        steady;
  logic        hold_req;

  rx_ring_header_walker_top uut (.*);

  ring_walk_checker walk_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .write_page_i    (write_page_i),
    .hdr_status_i    (hdr_status_i),
    .hdr_next_page_i (hdr_next_page_i),
    .hdr_len_low_i   (hdr_len_low_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .outcome_i       (outcome_o),
    .frame_len_i     (frame_len_o),
    .first_addr_i    (first_addr_o),
    .first_count_i   (first_count_o),
    .second_addr_i   (second_addr_o),
    .second_count_i  (second_count_o),
    .boundary_page_i (boundary_page_o),
    .next_page_o     (ring_ptr),
    .pending_o       (pending),
    .errors_o        (errors),
    .delivered_o     (n_delivered),
    .split_o         (n_split),
    .dropped_o       (n_dropped),
    .resets_o        (n_resets),
    .empty_o         (n_empty)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  // mostly headers that continue the ring walk from the predicted pointer
  function automatic void pick_header(output logic [7:0] wp, st, nx, ll);
    int         roll, ring_pages, max_span, span;
    logic [7:0] cur;
    cur  = ring_ptr;
    roll = $urandom_range(99);
    wp   = $urandom;
    st   = $urandom;
    nx   = $urandom;
    ll   = $urandom;
    if (roll < 12) return;
    if (roll < 20) begin
      wp = cur;
    end else if (wp == cur) begin
      wp = cur ^ 8'h01;
    end
    if (roll >= 30) st = {st[7:4], STAT_GOOD[3:0]};
    if (cfg_start >= cfg_stop) return;
    ring_pages = int'(cfg_stop) - int'(cfg_start);
    max_span   = int'(cfg_max) / int'(PAGE_BYTES) + 2;
    if ($urandom_range(3) != 0 && max_span > 8) max_span = 8;
    if (max_span > ring_pages) max_span = ring_pages;
    span = $urandom_range(max_span, 1);
    if (cur >= cfg_start && cur < cfg_stop) begin
      nx = 8'(int'(cfg_start) + (int'(cur) - int'(cfg_start) + span) % ring_pages);
    end else begin
      nx = 8'($urandom_range(int'(cfg_stop) - 1, int'(cfg_start)));
    end
  endfunction

  // optional gap, then offer one item and wait for it to be taken
  task automatic send_item(input bit pick, input logic [7:0] wp, st, nx, ll);
    logic [7:0] w, s, n, l;
    if (!steady && $urandom_range(99) < 11) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    {w, s, n, l} = {wp, st, nx, ll};
    if (pick) pick_header(w, s, n, l);
    in_valid_i      <= 1'b1;
    write_page_i    <= w;
    hdr_status_i    <= s;
    hdr_next_page_i <= n;
    hdr_len_low_i   <= l;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_ring(input logic [7:0] start_pg, stop_pg, input logic [15:0] max_l);
    cfg_start = start_pg;
    cfg_stop  = stop_pg;
    cfg_max   = max_l;
    n_settings++;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RING_START;
    cfg_wdata_i <= {8'h00, start_pg};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_RING_STOP;
    cfg_wdata_i <= {8'h00, stop_pg};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MAX_LEN;
    cfg_wdata_i <= max_l;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [7:0]  s_pg, p_pg;
    logic [15:0] m_len;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_RING_START;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    write_page_i    = '0;
    hdr_status_i    = '0;
    hdr_next_page_i = '0;
    hdr_len_low_i   = '0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    n_items         = 0;
    n_settings      = 1;
    cfg_start       = RESET_START_PAGE;
    cfg_stop        = RESET_STOP_PAGE;
    cfg_max         = RESET_MAX_LEN;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // ring registers as they come out of reset
    send_item(0, 8'd70, 8'h01, 8'd71, 8'd64);   // ring empty
    send_item(0, 8'd0, 8'h01, 8'd71, 8'd64);    // shortest frame
    send_item(0, 8'd255, 8'h21, 8'd72, 8'd63);  // one byte short
    send_item(0, 8'd0, 8'h01, 8'd76, 8'd238);   // longest frame
    send_item(0, 8'd0, 8'h01, 8'd82, 8'd239);   // one byte too long
    send_item(0, 8'd0, 8'h01, 8'h10, 8'd100);   // next page below the ring
    send_item(0, 8'd0, 8'h01, 8'd128, 8'd100);  // next page at the ring stop
    send_item(0, 8'd0, 8'h01, 8'd72, 8'd200);
    send_item(0, 8'd0, 8'h02, 8'd73, 8'd100);   // bad status
    send_item(0, 8'd0, 8'h00, 8'd74, 8'd128);
    send_item(0, 8'd0, 8'hff, 8'd75, 8'd128);
    send_item(0, 8'd0, 8'h01, 8'd77, 8'd253);   // count byte in the header tail
    send_item(0, 8'd0, 8'hf1, 8'd79, 8'd255);
    send_item(0, 8'd0, 8'h01, 8'd79, 8'd100);   // next page equals current
    quiesce();
    set_ring(8'd70, 8'd80, 16'hffff);
    send_item(0, 8'd0, 8'h01, 8'd78, 8'd100);
    send_item(0, 8'd0, 8'h01, 8'd71, 8'd0);     // frame ends right at the stop
    send_item(0, 8'd0, 8'h01, 8'd79, 8'd10);
    send_item(0, 8'd0, 8'h01, 8'd72, 8'd200);   // split at the stop
    send_item(0, 8'd0, 8'h01, 8'd70, 8'd50);    // boundary wraps to the last page before the stop
    send_item(0, 8'd0, 8'h01, 8'd79, 8'd10);
    quiesce();
    set_ring(8'd70, 8'd78, 16'hffff);
    send_item(0, 8'd0, 8'h01, 8'd75, 8'd100);   // pointer beyond the ring stop
    quiesce();
    set_ring(8'd200, 8'd100, 16'd1514);         // start above stop
    send_item(0, 8'd0, 8'h01, 8'd150, 8'd100);
    send_item(0, 8'd200, 8'h01, 8'd0, 8'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      case (ph)
        0: begin s_pg = 8'd1;   p_pg = 8'd255; m_len = 16'hffff; end
        1: begin s_pg = 8'd1;   p_pg = 8'd2;   m_len = 16'd60;   end
        2: begin s_pg = 8'd70;  p_pg = 8'd128; m_len = 16'd1514; end
        3: begin s_pg = 8'd32;  p_pg = 8'd40;  m_len = 16'hffff; end
        4: begin s_pg = 8'd255; p_pg = 8'd2;   m_len = 16'd1514; end
        5: begin s_pg = 8'd12;  p_pg = 8'd0;   m_len = 16'd1514; end
        6: begin s_pg = 8'd64;  p_pg = 8'd96;  m_len = 16'd1518; end
        7: begin s_pg = 8'd12;  p_pg = 8'd64;  m_len = 16'd600;  end
        default: begin
          s_pg  = 8'($urandom_range(200, 1));
          p_pg  = 8'($urandom_range(255, int'(s_pg) + 1));
          m_len = 16'($urandom_range(65535, 60));
        end
      endcase
      set_ring(s_pg, p_pg, m_len);
      // one long stretch where neither side idles
      steady = (ph == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(1, 8'd0, 8'd0, 8'd0, 8'd0);
        // result side stalls while items keep coming
        if (ph == 3 && i == 20) hold_req = 1'b1;
        if (i == 44) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("%0d headers walked under %0d ring settings", n_items, n_settings);
    $display("delivered %0d (%0d split at the stop), dropped %0d, resets %0d, empty %0d",
             n_delivered, n_split, n_dropped, n_resets, n_empty);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
